### rtl/core/csrs_pkg.sv
`default_nettype none

package csrs_pkg;

  // Default sizes of the storage.
  localparam int unsigned DefMaxWidth     = 64;
  localparam int unsigned DefMaxHeight    = 64;
  localparam int unsigned DefMaxNonzeros  = 4096;
  localparam int unsigned DefValueBits    = 32;

  // Fixed widths of the channel fields.
  localparam int unsigned ElemW     = 32;
  localparam int unsigned ColW      = 6;
  localparam int unsigned RowW      = 6;
  localparam int unsigned SizeW     = 7;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 7;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgDataKind = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgRowWidth = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgRowCount = 2'd2;

  // Request codes.
  localparam logic ReqLoad = 1'b0;
  localparam logic ReqRead = 1'b1;

  typedef enum logic [1:0] {
    StIdle,
    StLookup,
    StEmit,
    StError
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic do_load;
    logic do_lookup;
    logic start_walk;
    logic emit;
    logic emit_err;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
    logic row_err;
    logic last_col;
  } status_t;

endpackage

`default_nettype wire

### rtl/core/csrs_if.sv
`default_nettype none

// Request channel: one load element or one row read per word.
interface csrs_req_if;
  import csrs_pkg::*;
  logic               valid;
  logic               ready;
  logic               req_type;
  logic [ElemW-1:0]   elem_value;
  logic [RowW-1:0]    row_index;

  modport source (output valid, output req_type, output elem_value, output row_index,
                  input ready);
  modport sink   (input valid, input req_type, input elem_value, input row_index,
                  output ready);
endinterface

// Response channel: one dense column per word.
interface csrs_rsp_if;
  import csrs_pkg::*;
  logic               valid;
  logic               ready;
  logic [ElemW-1:0]   out_value;
  logic [ColW-1:0]    out_column;
  logic               last_of_row;
  logic               read_error;

  modport source (output valid, output out_value, output out_column, output last_of_row,
                  output read_error, input ready);
  modport sink   (input valid, input out_value, input out_column, input last_of_row,
                  input read_error, output ready);
endinterface

// Configuration write channel.
interface csrs_cfg_if;
  import csrs_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CfgIdxW-1:0]   index;
  logic [CfgDataW-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### rtl/core/csrs_ctrl.sv
`default_nettype none

module csrs_ctrl (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              req_valid_i,
  input  wire              req_type_i,
  output logic             req_ready_o,
  input  csrs_pkg::status_t sts_i,
  output csrs_pkg::cmd_t   cmd_o
);
  import csrs_pkg::*;

  state_e state_q, state_d;
  logic   req_acc;

  assign req_acc = req_valid_i && req_ready_o;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (req_acc && (req_type_i == ReqRead)) begin
          state_d = StLookup;
        end
      end
      StLookup: begin
        state_d = sts_i.row_err ? StError : StEmit;
      end
      StEmit: begin
        if (sts_i.out_free && sts_i.last_col) begin
          state_d = StIdle;
        end
      end
      StError: begin
        if (sts_i.out_free) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // Outputs.
  always_comb begin
    req_ready_o = 1'b0;
    cmd_o       = '0;
    unique case (state_q)
      StIdle: begin
        req_ready_o      = 1'b1;
        cmd_o.do_load    = req_acc && (req_type_i == ReqLoad);
        cmd_o.do_lookup  = req_acc && (req_type_i == ReqRead);
      end
      StLookup: begin
        cmd_o.start_walk = 1'b1;
      end
      StEmit: begin
        cmd_o.emit       = sts_i.out_free;
      end
      StError: begin
        cmd_o.emit_err   = sts_i.out_free;
      end
      default: begin
        req_ready_o      = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

### rtl/core/csrs_datapath.sv
`default_nettype none

module csrs_datapath #(
  parameter int unsigned MAX_WIDTH    = csrs_pkg::DefMaxWidth,
  parameter int unsigned MAX_HEIGHT   = csrs_pkg::DefMaxHeight,
  parameter int unsigned MAX_NONZEROS = csrs_pkg::DefMaxNonzeros,
  parameter int unsigned VALUE_BITS   = csrs_pkg::DefValueBits
) (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  csrs_pkg::cmd_t                  cmd_i,
  output csrs_pkg::status_t               sts_o,
  input  wire [csrs_pkg::ElemW-1:0]       elem_value_i,
  input  wire [csrs_pkg::RowW-1:0]        row_index_i,
  input  wire                             cfg_we_i,
  input  wire [csrs_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  wire [csrs_pkg::CfgDataW-1:0]    cfg_data_i,
  output logic                            rsp_valid_o,
  input  wire                             rsp_ready_i,
  output logic [csrs_pkg::ElemW-1:0]      out_value_o,
  output logic [csrs_pkg::ColW-1:0]       out_column_o,
  output logic                            last_of_row_o,
  output logic                            read_error_o
);
  import csrs_pkg::*;

  localparam int unsigned StoreBits = (VALUE_BITS < ElemW) ? VALUE_BITS : ElemW;
  localparam int unsigned NzW       = $clog2(MAX_NONZEROS + 1);
  localparam int unsigned VsAw      = (MAX_NONZEROS > 1) ? $clog2(MAX_NONZEROS) : 1;
  localparam int unsigned RpAw      = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam logic [ElemW-1:0] ValMask =
      (StoreBits >= ElemW) ? {ElemW{1'b1}} : ((ElemW'(1) << StoreBits) - ElemW'(1));
  localparam logic [ElemW-1:0] SignMask =
      (VALUE_BITS <= ElemW) ? (ElemW'(1) << (VALUE_BITS - 1)) : '0;
  localparam logic [SizeW-1:0] WCap  = SizeW'(MAX_WIDTH);
  localparam logic [SizeW-1:0] HCap  = (MAX_HEIGHT > 127) ? 7'd127 : SizeW'(MAX_HEIGHT);
  localparam logic [NzW-1:0]   NzCap = NzW'(MAX_NONZEROS);

  // Stores.
  logic [StoreBits-1:0] value_mem [MAX_NONZEROS];
  logic [ColW-1:0]      col_mem   [MAX_NONZEROS];
  logic [NzW-1:0]       rp_mem    [MAX_HEIGHT];

  // Configuration and load state.
  logic             data_kind_q;
  logic [SizeW-1:0] row_width_q, row_count_q;
  logic [ColW-1:0]  load_col_q, load_col_d;
  logic [SizeW-1:0] rows_done_q, rows_done_d;
  logic [NzW-1:0]   nz_cnt_q, nz_cnt_d;

  // Read walk state.
  logic [NzW-1:0]       rp_lo_q, rp_hi_q;
  logic                 row_zero_q, err_q;
  logic [NzW-1:0]       k_q, k_d, end_q;
  logic [ColW-1:0]      col_q;
  logic [StoreBits-1:0] vs_rdata_q;
  logic [ColW-1:0]      cs_rdata_q;

  logic [SizeW-1:0] w_eff, h_eff;
  logic             cfg_hit, restart, is_zero, store, wrap, match, last_col;
  logic [ElemW-1:0] v_masked, zero_mask;
  logic [ColW-1:0]  base_col;
  logic [SizeW-1:0] base_rows, col_next;
  logic [NzW-1:0]   base_nz, nz_new, walk_start;

  // Effective matrix size.
  always_comb begin
    if (row_width_q == '0) begin
      w_eff = SizeW'(1);
    end else if (row_width_q > WCap) begin
      w_eff = WCap;
    end else begin
      w_eff = row_width_q;
    end
    if (row_count_q == '0) begin
      h_eff = SizeW'(1);
    end else if (row_count_q > HCap) begin
      h_eff = HCap;
    end else begin
      h_eff = row_count_q;
    end
  end

  assign cfg_hit = cfg_we_i && ((cfg_index_i == CfgDataKind) || (cfg_index_i == CfgRowWidth) ||
                                (cfg_index_i == CfgRowCount));

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_kind_q <= 1'b0;
      row_width_q <= 7'd64;
      row_count_q <= 7'd64;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgDataKind: data_kind_q <= cfg_data_i[0];
        CfgRowWidth: row_width_q <= cfg_data_i;
        CfgRowCount: row_count_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Load step: a finished matrix restarts, non-zero elements are appended while space remains.
  always_comb begin
    restart   = rows_done_q >= h_eff;
    base_col  = restart ? '0 : load_col_q;
    base_rows = restart ? '0 : rows_done_q;
    base_nz   = restart ? '0 : nz_cnt_q;
    v_masked  = elem_value_i & ValMask;
    zero_mask = data_kind_q ? (ValMask & ~SignMask) : ValMask;
    is_zero   = (v_masked & zero_mask) == '0;
    store     = !is_zero && (base_nz < NzCap);
    nz_new    = base_nz + NzW'(store);
    col_next  = {1'b0, base_col} + SizeW'(1);
    wrap      = col_next >= w_eff;

    load_col_d  = load_col_q;
    rows_done_d = rows_done_q;
    nz_cnt_d    = nz_cnt_q;
    if (cfg_hit) begin
      load_col_d  = '0;
      rows_done_d = '0;
      nz_cnt_d    = '0;
    end else if (cmd_i.do_load) begin
      nz_cnt_d    = nz_new;
      load_col_d  = wrap ? '0 : col_next[ColW-1:0];
      rows_done_d = wrap ? base_rows + SizeW'(1) : base_rows;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_col_q  <= '0;
      rows_done_q <= '0;
      nz_cnt_q    <= '0;
    end else begin
      load_col_q  <= load_col_d;
      rows_done_q <= rows_done_d;
      nz_cnt_q    <= nz_cnt_d;
    end
  end

  // Value and column store writes.
  always_ff @(posedge clk_i) begin
    if (cmd_i.do_load && !cfg_hit && store) begin
      value_mem[VsAw'(base_nz)] <= v_masked[StoreBits-1:0];
      col_mem[VsAw'(base_nz)]   <= base_col;
    end
  end

  // Row pointer store: entry i holds the count at the end of row i.
  always_ff @(posedge clk_i) begin
    if (cmd_i.do_load && !cfg_hit && wrap) begin
      rp_mem[RpAw'(base_rows)] <= nz_new;
    end
  end

  // Row lookup: both bounds of the row are read at once.
  always_ff @(posedge clk_i) begin
    if (cmd_i.do_lookup) begin
      rp_lo_q    <= rp_mem[RpAw'(row_index_i - RowW'(1))];
      rp_hi_q    <= rp_mem[RpAw'(row_index_i)];
      row_zero_q <= row_index_i == '0;
      err_q      <= ({1'b0, row_index_i} >= h_eff) || ({1'b0, row_index_i} >= rows_done_q);
    end
  end

  assign walk_start = row_zero_q ? '0 : rp_lo_q;
  assign match      = (k_q < end_q) && (cs_rdata_q == col_q);
  assign last_col   = ({1'b0, col_q} + SizeW'(1)) == w_eff;

  // Entry pointer; the store is read at its next value so data tracks k_q.
  always_comb begin
    k_d = k_q;
    if (cmd_i.start_walk) begin
      k_d = walk_start;
    end else if (cmd_i.emit && match) begin
      k_d = k_q + NzW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    k_q        <= k_d;
    vs_rdata_q <= value_mem[VsAw'(k_d)];
    cs_rdata_q <= col_mem[VsAw'(k_d)];
    if (cmd_i.start_walk) begin
      end_q <= rp_hi_q;
      col_q <= '0;
    end else if (cmd_i.emit) begin
      col_q <= col_q + ColW'(1);
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_o <= 1'b0;
    end else if (cmd_i.emit || cmd_i.emit_err) begin
      rsp_valid_o <= 1'b1;
    end else if (rsp_ready_i) begin
      rsp_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_value_o   <= match ? ElemW'(vs_rdata_q) : '0;
      out_column_o  <= col_q;
      last_of_row_o <= last_col;
      read_error_o  <= 1'b0;
    end else if (cmd_i.emit_err) begin
      out_value_o   <= '0;
      out_column_o  <= '0;
      last_of_row_o <= 1'b1;
      read_error_o  <= 1'b1;
    end
  end

  assign sts_o.out_free = !rsp_valid_o || rsp_ready_i;
  assign sts_o.row_err  = err_q;
  assign sts_o.last_col = last_col;

endmodule

`default_nettype wire

### rtl/core/csr_sparse_matrix_store_top.sv
`default_nettype none

// Channel | Dir | Payload                                         | Word
// req_i   | in  | req_type, elem_value, row_index                 | one load or one row read
// rsp_o   | out | out_value, out_column, last_of_row, read_error  | one dense column
// cfg_i   | in  | index, data                                     | one register write
//
// A load is written as it is taken; the next request is taken in the following cycle.
// A row read first reads the row pointers, then the first stored entry (lookup state),
// and then emits one column per cycle while the output register is free; a refused read emits a single error word.
// The output register lets a read start while the last word waits to be taken;
// a stalled response holds the column walk in place.
// Reset clears the control state and the load position; the stores need no clearing.
module csr_sparse_matrix_store_top #(
  parameter int unsigned MAX_WIDTH    = csrs_pkg::DefMaxWidth,
  parameter int unsigned MAX_HEIGHT   = csrs_pkg::DefMaxHeight,
  parameter int unsigned MAX_NONZEROS = csrs_pkg::DefMaxNonzeros,
  parameter int unsigned VALUE_BITS   = csrs_pkg::DefValueBits
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  csrs_req_if.sink    req_i,
  csrs_rsp_if.source  rsp_o,
  csrs_cfg_if.sink    cfg_i
);
  import csrs_pkg::*;

  cmd_t    cmd;
  status_t sts;

  // Register writes are always taken.
  assign cfg_i.ready = 1'b1;

  csrs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_type_i  (req_i.req_type),
    .req_ready_o (req_i.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  csrs_datapath #(
    .MAX_WIDTH    (MAX_WIDTH),
    .MAX_HEIGHT   (MAX_HEIGHT),
    .MAX_NONZEROS (MAX_NONZEROS),
    .VALUE_BITS   (VALUE_BITS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .elem_value_i  (req_i.elem_value),
    .row_index_i   (req_i.row_index),
    .cfg_we_i      (cfg_i.valid),
    .cfg_index_i   (cfg_i.index),
    .cfg_data_i    (cfg_i.data),
    .rsp_valid_o   (rsp_o.valid),
    .rsp_ready_i   (rsp_o.ready),
    .out_value_o   (rsp_o.out_value),
    .out_column_o  (rsp_o.out_column),
    .last_of_row_o (rsp_o.last_of_row),
    .read_error_o  (rsp_o.read_error)
  );

endmodule

`default_nettype wire
